@@ sv/kruskal_mst_weight_macros.svh @@
// Assertion macros shared by the kruskal_mst_weight checkers.
`ifndef KRUSKAL_MST_WEIGHT_MACROS_SVH
`define KRUSKAL_MST_WEIGHT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define KMW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define KMW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/kmw_pkg.sv @@
// Shared types, widths and the edge ordering function for kruskal_mst_weight.
`default_nettype none
package kmw_pkg;

  localparam int EP_W    = 10;  // vertex index width
  localparam int W_W     = 32;  // edge weight width
  localparam int CFG_W   = 11;  // vertex_count register width
  localparam int CNT_W   = 17;  // holds vertex counts up to 131071
  localparam int SUM_W   = 64;
  localparam int TAKEN_W = 10;
  localparam int Q_DEPTH = 4;

  typedef struct packed {
    logic signed [W_W-1:0] w;
    logic [EP_W-1:0]       b;
    logic [EP_W-1:0]       a;
  } edge_t;

  typedef struct packed {
    edge_t e;
    logic  keep;   // edge passes range and capacity checks
    logic  last;
    logic  err;    // any drop seen in this graph so far, this word included
  } qent_t;

  function automatic logic edge_less(edge_t x, edge_t y);
    if (x.w != y.w) return ($signed(x.w) < $signed(y.w));
    if (x.a != y.a) return (x.a < y.a);
    return (x.b < y.b);
  endfunction

endpackage
`default_nettype wire

@@ sv/kmw_front.sv @@
// Front end: config register, edge range and capacity checks, drop tracking.
`default_nettype none
module kmw_front import kmw_pkg::*; #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [EP_W-1:0]   edge_from,
  input  wire logic [EP_W-1:0]   edge_to,
  input  wire logic [W_W-1:0]    edge_weight,
  input  wire logic              last_edge,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output qent_t                  q_data,
  output logic [CNT_W-1:0]       eff_n
);

  localparam int FW = $clog2(MAX_EDGES + 1);

  logic [CFG_W-1:0] vc_r;
  logic [FW-1:0]    cnt_r;
  logic             err_r;
  logic [CNT_W-1:0] vc_ext;
  logic             keep;
  logic             acc;

  assign cfg_ready = 1'b1;
  assign vc_ext    = CNT_W'(vc_r);

  always_comb begin
    if (vc_r == '0) begin
      eff_n = CNT_W'(1);
    end else if (vc_ext > CNT_W'(MAX_VERTICES)) begin
      eff_n = CNT_W'(MAX_VERTICES);
    end else begin
      eff_n = vc_ext;
    end
  end

  assign keep = (CNT_W'(edge_from) < eff_n) && (CNT_W'(edge_to) < eff_n) &&
                (cnt_r < FW'(MAX_EDGES));

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign acc      = in_valid && q_ready;

  always_comb begin
    q_data.e.a  = edge_from;
    q_data.e.b  = edge_to;
    q_data.e.w  = edge_weight;
    q_data.keep = keep;
    q_data.last = last_edge;
    q_data.err  = err_r | ~keep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r  <= CFG_W'(1);
      cnt_r <= '0;
      err_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        vc_r <= cfg_data;
      end
      if (acc) begin
        if (last_edge) begin
          cnt_r <= '0;
          err_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + FW'(keep);
          err_r <= err_r | ~keep;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/kmw_queue.sv @@
// Short queue of classified edge words between front and back.
`default_nettype none
module kmw_queue import kmw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  qent_t     wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output qent_t     rd_data
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CW    = $clog2(Q_DEPTH + 1);

  qent_t            slots [Q_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CW-1:0]    cnt_r;
  logic             push, pop;

  assign wr_ready = (cnt_r != CW'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = slots[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PTR_W'(1);
      if (pop)  rp_r <= rp_r + PTR_W'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule
`default_nettype wire

@@ sv/kmw_back.sv @@
// Back end: edge store, merge sort, union-find walk and result register.
`default_nettype none
module kmw_back import kmw_pkg::*; #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  output logic                    q_ready,
  input  qent_t                   q_data,
  input  wire logic [CNT_W-1:0]   eff_n,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [SUM_W-1:0]        total_weight,
  output logic [TAKEN_W-1:0]      taken_edges,
  output logic                    connected,
  output logic                    input_error
);

  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FW  = $clog2(MAX_EDGES + 1);
  localparam int SW  = FW + 2;
  localparam int PD  = (MAX_VERTICES < 1024) ? MAX_VERTICES : 1024;
  localparam int PW  = $clog2(PD);
  localparam int SZW = $clog2(PD + 1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_SMG   = 4'd3;
  localparam logic [3:0] S_INIT  = 4'd4;
  localparam logic [3:0] S_EDGE  = 4'd5;
  localparam logic [3:0] S_EGET  = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_CRD   = 4'd9;
  localparam logic [3:0] S_CCHK  = 4'd10;
  localparam logic [3:0] S_UNI   = 4'd11;
  localparam logic [3:0] S_UN2   = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  // edge store, ping-pong banks for the merge passes
  edge_t bank0 [MAX_EDGES];
  edge_t bank1 [MAX_EDGES];
  logic  [PW-1:0]  par_mem  [PD];
  logic  [SZW-1:0] size_mem [PD];

  logic [3:0]       st_r, st_nxt;
  logic [FW-1:0]    fill_r, e_r;
  logic             err_r, src_r, ph_r;
  logic [SW-1:0]    wid_r, lo_r, mid_r, hi_r, i_r, j_r, k_r;
  logic [PW-1:0]    iv_r, cur_r, start_r, root_r, ra_r, eb_r;
  logic [W_W-1:0]   ew_r;
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] taken_r;
  edge_t            rd0_r, rd1_r;
  logic [PW-1:0]    prd_r;
  logic [SZW-1:0]   srd0_r, srd1_r;

  logic             ov_r, oconn_r, oerr_r;
  logic [SUM_W-1:0] osum_r;
  logic [TAKEN_W-1:0] otaken_r;

  // memory controls
  logic             we, wbank, rbank;
  logic [AW-1:0]    waddr, ra0, ra1;
  edge_t            wdata;
  logic             pwe, swe;
  logic [PW-1:0]    pwa, pwd, pra, swa, sra0, sra1;
  logic [SZW-1:0]   swd;

  logic [SW-1:0]    fill_s, wid2, lo_n, lo_w, lo_2w;
  logic             take_i, run_end, pass_end, sort_end, e_end, small_a;
  logic [FW-1:0]    fill_after;
  logic             out_load;

  assign fill_s     = SW'(fill_r);
  assign wid2       = {wid_r[SW-2:0], 1'b0};
  assign lo_w       = lo_r + wid_r;
  assign lo_2w      = lo_r + wid2;
  assign lo_n       = lo_2w;
  assign take_i     = (i_r < mid_r) && ((j_r >= hi_r) || !edge_less(rd1_r, rd0_r));
  assign run_end    = ((k_r + SW'(1)) == hi_r);
  assign pass_end   = (lo_n >= fill_s);
  assign sort_end   = (wid2 >= fill_s);
  assign e_end      = ((e_r + FW'(1)) == fill_r);
  assign fill_after = fill_r + FW'(q_data.keep);
  assign small_a    = (srd0_r < srd1_r);
  assign out_load   = (st_r == S_DONE) && (!ov_r || out_ready);
  assign q_ready    = (st_r == S_LOAD);

  always_comb begin
    st_nxt = st_r;
    we     = 1'b0;
    wbank  = 1'b0;
    waddr  = fill_r[AW-1:0];
    wdata  = q_data.e;
    rbank  = src_r;
    ra0    = i_r[AW-1:0];
    ra1    = j_r[AW-1:0];
    pwe    = 1'b0;
    pwa    = iv_r;
    pwd    = iv_r;
    pra    = cur_r;
    swe    = 1'b0;
    swa    = iv_r;
    swd    = SZW'(1);
    sra0   = ra_r;
    sra1   = root_r;
    case (st_r)
      S_LOAD: begin
        we = q_valid && q_data.keep;
        if (q_valid && q_data.last) begin
          st_nxt = (fill_after > FW'(1)) ? S_SETUP : S_INIT;
        end
      end
      S_SETUP: st_nxt = S_SRD;
      S_SRD:   st_nxt = S_SMG;
      S_SMG: begin
        we    = 1'b1;
        wbank = ~src_r;
        waddr = k_r[AW-1:0];
        wdata = take_i ? rd0_r : rd1_r;
        if (!run_end)      st_nxt = S_SRD;
        else if (!pass_end) st_nxt = S_SETUP;
        else               st_nxt = sort_end ? S_INIT : S_SETUP;
      end
      S_INIT: begin
        pwe = 1'b1;
        swe = 1'b1;
        if (iv_r == PW'(PD - 1)) begin
          st_nxt = (fill_r == '0) ? S_DONE : S_EDGE;
        end
      end
      S_EDGE: begin
        ra0    = e_r[AW-1:0];
        st_nxt = S_EGET;
      end
      S_EGET: st_nxt = S_FRD;
      S_FRD:  st_nxt = S_FCHK;
      S_FCHK: st_nxt = (prd_r == cur_r) ? S_CRD : S_FRD;
      S_CRD: begin
        pra    = start_r;
        st_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (prd_r == root_r) begin
          st_nxt = ph_r ? S_UNI : S_FRD;
        end else begin
          // compress: point this node straight at the root
          pwe    = 1'b1;
          pwa    = start_r;
          pwd    = root_r;
          st_nxt = S_CRD;
        end
      end
      S_UNI: begin
        if (ra_r == root_r) st_nxt = e_end ? S_DONE : S_EDGE;
        else                st_nxt = S_UN2;
      end
      S_UN2: begin
        swe    = 1'b1;
        pwe    = 1'b1;
        swa    = small_a ? root_r : ra_r;
        swd    = srd0_r + srd1_r;
        pwa    = small_a ? ra_r : root_r;
        pwd    = small_a ? root_r : ra_r;
        st_nxt = e_end ? S_DONE : S_EDGE;
      end
      S_DONE: begin
        if (out_load) st_nxt = S_LOAD;
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (we) begin
      if (wbank) bank1[waddr] <= wdata;
      else       bank0[waddr] <= wdata;
    end
    rd0_r <= rbank ? bank1[ra0] : bank0[ra0];
    rd1_r <= rbank ? bank1[ra1] : bank0[ra1];
  end

  always_ff @(posedge clk) begin
    if (pwe) par_mem[pwa] <= pwd;
    prd_r <= par_mem[pra];
  end

  always_ff @(posedge clk) begin
    if (swe) size_mem[swa] <= swd;
    srd0_r <= size_mem[sra0];
    srd1_r <= size_mem[sra1];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_LOAD;
      fill_r <= '0;
      err_r  <= 1'b0;
      src_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_LOAD && q_valid) begin
        fill_r <= fill_after;
        if (q_data.last) begin
          err_r <= q_data.err;
          src_r <= 1'b0;
        end
      end
      if (st_r == S_SMG && run_end && pass_end) begin
        src_r <= ~src_r;
      end
      if (out_load) begin
        fill_r <= '0;
        ov_r   <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (st_r != S_INIT) iv_r <= '0;
    case (st_r)
      S_LOAD: begin
        wid_r <= SW'(1);
        lo_r  <= '0;
      end
      S_SETUP: begin
        mid_r <= (lo_w < fill_s) ? lo_w : fill_s;
        hi_r  <= (lo_2w < fill_s) ? lo_2w : fill_s;
        j_r   <= (lo_w < fill_s) ? lo_w : fill_s;
        i_r   <= lo_r;
        k_r   <= lo_r;
      end
      S_SMG: begin
        if (take_i) i_r <= i_r + SW'(1);
        else        j_r <= j_r + SW'(1);
        k_r <= k_r + SW'(1);
        if (run_end) begin
          if (pass_end) begin
            lo_r  <= '0;
            wid_r <= wid2;
          end else begin
            lo_r <= lo_n;
          end
        end
      end
      S_INIT: begin
        iv_r    <= iv_r + PW'(1);
        e_r     <= '0;
        sum_r   <= '0;
        taken_r <= '0;
      end
      S_EGET: begin
        cur_r   <= rd0_r.a[PW-1:0];
        start_r <= rd0_r.a[PW-1:0];
        eb_r    <= rd0_r.b[PW-1:0];
        ew_r    <= rd0_r.w;
        ph_r    <= 1'b0;
      end
      S_FCHK: begin
        if (prd_r == cur_r) root_r <= cur_r;
        else                cur_r  <= prd_r;
      end
      S_CCHK: begin
        if (prd_r == root_r) begin
          if (!ph_r) begin
            ra_r    <= root_r;
            ph_r    <= 1'b1;
            cur_r   <= eb_r;
            start_r <= eb_r;
          end
        end else begin
          start_r <= prd_r;
        end
      end
      S_UNI: begin
        if (ra_r == root_r) e_r <= e_r + FW'(1);
      end
      S_UN2: begin
        e_r     <= e_r + FW'(1);
        taken_r <= taken_r + CNT_W'(1);
        sum_r   <= sum_r + {{(SUM_W-W_W){ew_r[W_W-1]}}, ew_r};
      end
      default: ;
    endcase
    if (out_load) begin
      osum_r   <= sum_r;
      otaken_r <= taken_r[TAKEN_W-1:0];
      oconn_r  <= (taken_r == (eff_n - CNT_W'(1)));
      oerr_r   <= err_r;
    end
  end

  assign out_valid    = ov_r;
  assign total_weight = osum_r;
  assign taken_edges  = otaken_r;
  assign connected    = oconn_r;
  assign input_error  = oerr_r;

endmodule
`default_nettype wire

@@ sv/kruskal_mst_weight.sv @@
// Top level of the minimum spanning forest weight block.
// Usage:
//   cfg_*  : write vertex_count (11 bits) while the block is idle; always ready.
//   in_*   : one edge per word; tdata = {weight, to, from}, tlast marks the
//            final edge of a graph. Loading takes one cycle per edge unless the queue is full.
//   out_*  : one result word per graph, sent after the last edge.
// After the last edge, for vertex table depth D: a merge sort of the stored
//   edges (each merged word waits on the registered read of the edge store,
//   and each run has a setup step), a reset of D entries of the union-find
//   tables, then per edge a fetch, two root walks with path compression, and
//   a union when the edge joins two sets.
// While computing, the input side stalls once the 4-word queue fills.
// The result sits in an output register; a stalled receiver holds it and
// the next graph's edges load meanwhile, but its result waits for the slot.
// Reset clears the edge count, the drop flag and the output valid flag, and
// sets vertex_count to 1.
`default_nettype none
module kruskal_mst_weight import kmw_pkg::*; #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [55:0]      in_tdata,   // edge_from[9:0], edge_to[19:10], edge_weight[51:20]
  input  wire logic             in_tlast,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [79:0]           out_tdata   // total_weight[63:0], taken_edges[73:64],
                                            // connected[74], input_error[75]
);

  logic             q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  qent_t            q_in_data, q_out_data;
  logic [CNT_W-1:0] eff_n;
  logic [SUM_W-1:0] total_weight;
  logic [TAKEN_W-1:0] taken_edges;
  logic             connected, input_error;

  kmw_front #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .edge_from   (in_tdata[9:0]),
    .edge_to     (in_tdata[19:10]),
    .edge_weight (in_tdata[51:20]),
    .last_edge   (in_tlast),
    .q_valid     (q_in_valid),
    .q_ready     (q_in_ready),
    .q_data      (q_in_data),
    .eff_n       (eff_n)
  );

  kmw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_in_valid),
    .wr_ready (q_in_ready),
    .wr_data  (q_in_data),
    .rd_valid (q_out_valid),
    .rd_ready (q_out_ready),
    .rd_data  (q_out_data)
  );

  kmw_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_out_valid),
    .q_ready      (q_out_ready),
    .q_data       (q_out_data),
    .eff_n        (eff_n),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .total_weight (total_weight),
    .taken_edges  (taken_edges),
    .connected    (connected),
    .input_error  (input_error)
  );

  assign out_tdata = {4'b0, input_error, connected, taken_edges, total_weight};

endmodule
`default_nettype wire

@@ sv/kmw_checker.sv @@
// Port-level checker for kruskal_mst_weight and its bind.
`default_nettype none
`include "kruskal_mst_weight_macros.svh"
module kmw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [79:0] out_tdata,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready
);

  `KMW_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result word changed while stalled")
  `KMW_ASSERT_IMP(a_out_known, out_tvalid, !$isunknown(out_tdata), "result word has unknown bits")
  `KMW_ASSERT_IMP(a_pad_zero, out_tvalid, out_tdata[79:76] == 4'b0, "result padding not zero")
  `KMW_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "config write not taken")

endmodule

bind kruskal_mst_weight kmw_checker u_kmw_checker (.*);
`default_nettype wire

@@ dv/kruskal_mst_weight_tb.sv @@
// Self-checking testbench for the minimum spanning forest weight block.
`default_nettype none
module kruskal_mst_weight_tb;
  import kmw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VMAX       = 1024;
  localparam int EMAX       = 4096;
  localparam int CYCLE_CAP  = 3000000;
  localparam int CFG_VCOUNT = 0;

  // Result bookkeeping: expected forest weights per graph.
  class forest_board;
    bit [51:0]   sorted_edges[$];   // {weight ^ sign, from, to}, ascending
    bit          drop_seen;
    int unsigned vcount;
    bit [75:0]   forest_q[$];
    int          errors;
    int          graphs;

    function new();
      vcount = 1;
      drop_seen = 0;
      errors = 0;
      graphs = 0;
    endfunction

    function void set_vcount(int unsigned v);
      vcount = v;
    endfunction

    function int unsigned eff_count();
      if (vcount == 0) return 1;
      if (vcount > VMAX) return VMAX;
      return vcount;
    endfunction

    function void note_edge(bit [9:0] a, bit [9:0] b, bit [31:0] w, bit last);
      int unsigned n;
      bit [51:0] key;
      int pos;
      int par[VMAX];
      int sz[VMAX];
      int ra, rb, t;
      longint sum;
      int taken;
      n = eff_count();
      if (a >= n || b >= n || sorted_edges.size() >= EMAX) begin
        drop_seen = 1;
      end else begin
        key = {w[31] ^ 1'b1, w[30:0], a, b};
        pos = sorted_edges.size();
        while (pos > 0 && sorted_edges[pos-1] > key) pos--;
        sorted_edges.insert(pos, key);
      end
      if (!last) return;
      for (int i = 0; i < VMAX; i++) begin
        par[i] = i;
        sz[i] = 1;
      end
      sum = 0;
      taken = 0;
      foreach (sorted_edges[e]) begin
        ra = sorted_edges[e][19:10];
        rb = sorted_edges[e][9:0];
        while (par[ra] != ra) ra = par[ra];
        while (par[rb] != rb) rb = par[rb];
        if (ra != rb) begin
          taken++;
          sum += longint'($signed({~sorted_edges[e][51], sorted_edges[e][50:20]}));
          if (sz[ra] < sz[rb]) begin
            t = ra; ra = rb; rb = t;
          end
          sz[ra] += sz[rb];
          par[rb] = ra;
        end
      end
      forest_q.insert(forest_q.size(),
                      {drop_seen, taken == int'(n) - 1, taken[9:0], sum[63:0]});
      sorted_edges.delete();
      drop_seen = 0;
    endfunction

    function void check_forest(bit [79:0] got);
      bit [75:0] exp;
      if (forest_q.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      exp = forest_q.pop_front();
      graphs++;
      if (got[63:0] != exp[63:0]) begin
        $error("total_weight exp %0d got %0d", $signed(exp[63:0]), $signed(got[63:0]));
        errors++;
      end
      if (got[73:64] != exp[73:64]) begin
        $error("taken_edges exp %0d got %0d", exp[73:64], got[73:64]);
        errors++;
      end
      if (got[74] != exp[74]) begin
        $error("connected exp %0d got %0d", exp[74], got[74]);
        errors++;
      end
      if (got[75] != exp[75]) begin
        $error("input_error exp %0d got %0d", exp[75], got[75]);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [55:0]      in_tdata;   // edge_from[9:0], edge_to[19:10], edge_weight[51:20]
  logic             in_tlast;
  logic             out_tvalid;
  logic             out_tready;
  logic [79:0]      out_tdata;  // total_weight[63:0], taken_edges[73:64],
                                // connected[74], input_error[75]

  forest_board board;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          edges_sent;
  longint      cycles;

  kruskal_mst_weight dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) board.check_forest(out_tdata);
  end

  task automatic write_vcount(int unsigned v);
    // drop the input and let the block finish before touching the register
    in_tvalid <= 0;
    while (board.forest_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    board.set_vcount(v);
  endtask

  task automatic send_edge(bit [9:0] a, bit [9:0] b, bit [31:0] w, bit last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {4'b0, w, b, a};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_edge(a, b, w, last);
    edges_sent++;
  endtask

  task automatic park_sender();
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  function automatic bit [31:0] pick_weight();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(7);
      2: return -$urandom_range(7);
      3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(200) - 100;
    endcase
  endfunction

  function automatic bit [9:0] pick_vertex(int unsigned n);
    if ($urandom_range(49) == 0) return 10'($urandom_range(VMAX - 1));
    return 10'($urandom_range(n - 1));
  endfunction

  // One graph of random edges over the configured vertex range, with the odd endpoint drawn from the full 10-bit range.
  task automatic send_graph(int len);
    int unsigned n;
    n = board.eff_count();
    for (int i = 0; i < len; i++)
      send_edge(pick_vertex(n), pick_vertex(n), pick_weight(), i == len - 1);
  endtask

  initial begin
    int target;
    cycles = 0;
    rst_n = 0;
    cfg_valid = 0;
    cfg_data = '0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tlast = 0;
    out_tready = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    edges_sent = 0;
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset vertex count, self loop, empty graph, extremes, drops
    send_edge(0, 0, 32'h7FFF_FFFF, 1);
    write_vcount(4);
    send_edge(0, 1, 32'h8000_0000, 0);
    send_edge(1, 2, 32'h8000_0000, 0);
    send_edge(2, 3, 32'h7FFF_FFFF, 0);
    send_edge(3, 3, 5, 0);
    send_edge(0, 3, 32'h8000_0000, 1);
    send_edge(9, 0, 1, 1);
    send_edge(2, 1, 7, 0);
    send_edge(1, 2, 7, 0);
    send_edge(0, 1023, 3, 1);
    write_vcount(0);
    send_edge(0, 0, 1, 0);
    send_edge(1, 0, 1, 1);
    write_vcount(2047);
    send_edge(1023, 0, 32'hFFFF_FFFF, 0);
    send_edge(682, 341, 32'h5555_5555, 0);
    send_edge(341, 682, 32'hAAAA_AAAA, 1);
    write_vcount(1024);
    send_edge(1023, 1022, 32'h0000_0001, 1);
    write_vcount(1);
    send_edge(0, 0, 0, 1);

    // random: three idling phases, several vertex counts each
    target = 900;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 50 : 0;
      recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 24 : 0;
      for (int s = 0; s < 4; s++) begin
        case ($urandom_range(4))
          0: write_vcount(1024);
          1: write_vcount($urandom_range(2047, 1025));
          2: write_vcount($urandom_range(3));
          default: write_vcount($urandom_range(24, 2));
        endcase
        while (edges_sent < target * (phase * 4 + s + 1) / 12)
          send_graph($urandom_range(16, 1));
      end
      park_sender();
    end

    while (board.forest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d edges over %0d graphs, vertex counts 0 to 2047,",
             edges_sent, board.graphs);
    $display("with stalls on both sides, dropped edges and self loops");
    if (board.errors == 0 && board.forest_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
